FILE: rtl/gtb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter package
// Shared constants, codes and types for the 4bpp glyph text blitter.
// ----------------------------------------------------------------------------
package gtb_pkg;

   localparam int DEF_SCREEN_WIDTH = 320;
   localparam int DEF_GLYPH_ROWS   = 12;
   localparam int DEF_GLYPH_COUNT  = 256;

   localparam int QUEUE_DEPTH   = 4;
   localparam int PALETTE_DEPTH = 16;
   localparam int PIXELS        = 8;
   // Enough bits for the largest font store (256 glyphs of 32 rows).
   localparam int WORD_INDEX_W  = 13;

   localparam logic [7:0]  CODE_BIAS     = 8'h0F;
   localparam logic [7:0]  SUBST_CODE    = 8'h3B;
   localparam logic [7:0]  CODE_SPACE    = 8'h01;
   localparam logic [7:0]  CODE_NEWLINE  = 8'h0A;
   localparam logic [31:0] SPACE_ADVANCE = 32'd6;
   localparam logic [31:0] GLYPH_ADVANCE = 32'h12;
   localparam logic [15:0] LINE_STEP     = 16'h0D;
   localparam logic [7:0]  LAST_CODE_RESET = 8'd127;

   typedef enum logic [1:0] {
      OP_DRAW         = 2'd0,
      OP_SET_CURSOR   = 2'd1,
      OP_LOAD_FONT    = 2'd2,
      OP_LOAD_PALETTE = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_FRAME_BASE = 1'b0,
      CSR_LAST_CODE  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      JOB_DRAW    = 2'd0,
      JOB_FONT    = 2'd1,
      JOB_PALETTE = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type            kind;
      logic [31:0]             address;
      logic [WORD_INDEX_W-1:0] index;
      logic [31:0]             value;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: rtl/gtb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter request channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface gtb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [7:0]         char_code;
   logic signed [15:0] cursor_x;
   logic signed [15:0] cursor_y;
   logic [11:0]        load_index;
   logic [31:0]        load_value;

   modport source (
      output valid, opcode, char_code, cursor_x, cursor_y, load_index, load_value,
      input  ready
   );
   modport sink (
      input  valid, opcode, char_code, cursor_x, cursor_y, load_index, load_value,
      output ready
   );
endinterface

FILE: rtl/gtb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter response channel
// Valid/ready channel that carries one glyph row write item.
// ----------------------------------------------------------------------------
interface gtb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_address;
   logic [15:0] color_0;
   logic [15:0] color_1;
   logic [15:0] color_2;
   logic [15:0] color_3;
   logic [15:0] color_4;
   logic [15:0] color_5;
   logic [15:0] color_6;
   logic [15:0] color_7;
   logic [7:0]  write_mask;
   logic        last_row;

   modport source (
      output valid, row_address, color_0, color_1, color_2, color_3,
             color_4, color_5, color_6, color_7, write_mask, last_row,
      input  ready
   );
   modport sink (
      input  valid, row_address, color_0, color_1, color_2, color_3,
             color_4, color_5, color_6, color_7, write_mask, last_row,
      output ready
   );
endinterface

FILE: rtl/gtb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter front end
// Accepts command items, keeps the cursor and queues draw and load jobs.
// ----------------------------------------------------------------------------
module gtb_front
   import gtb_pkg::*;
#(
   parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
   parameter int GLYPH_ROWS   = DEF_GLYPH_ROWS,
   parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   gtb_req_if.sink          req_chan,
   input  logic [31:0]      frame_base,
   input  logic [7:0]       last_code,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   localparam int FONT_WORDS = GLYPH_COUNT * GLYPH_ROWS;

   logic [31:0] cursor_ff, cursor_in;
   logic [15:0] line_x_ff, line_x_in;
   logic [15:0] line_y_ff, line_y_in;

   logic [WORD_INDEX_W-1:0] base_tab [256];
   logic                    accept;
   logic [15:0]             place_x;
   logic [15:0]             place_y;
   logic [31:0]             place_addr;
   logic [31:0]             y_rows;
   logic [7:0]              glyph_code;
   logic [7:0]              glyph_index;

   // First font word of each glyph, already reduced modulo the store depth.
   for (genvar G = 0; G < 256; G++) begin : g_base
      localparam int BaseWord = ((G / 8) * 8 * GLYPH_ROWS + G % 8) % FONT_WORDS;
      assign base_tab[G] = WORD_INDEX_W'(BaseWord);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         line_x_ff <= '0;
         line_y_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
         line_x_ff <= line_x_in;
         line_y_ff <= line_y_in;
      end
   end

   always_comb begin
      req_chan.ready = !q_status.full;
      accept         = req_chan.valid && req_chan.ready;

      if (opcode_type'(req_chan.opcode) == OP_SET_CURSOR) begin
         place_x = req_chan.cursor_x;
         place_y = req_chan.cursor_y;
      end else begin
         place_x = line_x_ff;
         place_y = line_y_ff + LINE_STEP;
      end
      y_rows     = {{16{place_y[15]}}, place_y} * 32'(SCREEN_WIDTH);
      place_addr = (({{16{place_x[15]}}, place_x} + y_rows) << 1) + frame_base;

      if (req_chan.char_code < CODE_BIAS || req_chan.char_code > last_code) begin
         glyph_code = SUBST_CODE;
      end else begin
         glyph_code = req_chan.char_code;
      end
      glyph_index = glyph_code - CODE_BIAS;

      cursor_in = cursor_ff;
      line_x_in = line_x_ff;
      line_y_in = line_y_ff;
      push      = 1'b0;
      push_job.kind    = JOB_DRAW;
      push_job.address = cursor_ff;
      push_job.index   = {1'b0, req_chan.load_index};
      push_job.value   = req_chan.load_value;

      if (accept) begin
         case (opcode_type'(req_chan.opcode))
            OP_DRAW: begin
               if (req_chan.char_code == CODE_SPACE) begin
                  cursor_in = cursor_ff + SPACE_ADVANCE;
               end else if (req_chan.char_code == CODE_NEWLINE) begin
                  line_y_in = place_y;
                  cursor_in = place_addr;
               end else begin
                  push           = 1'b1;
                  push_job.index = base_tab[glyph_index];
                  cursor_in      = cursor_ff + GLYPH_ADVANCE;
               end
            end
            OP_SET_CURSOR: begin
               line_x_in = place_x;
               line_y_in = place_y;
               cursor_in = place_addr;
            end
            OP_LOAD_FONT: begin
               push_job.kind = JOB_FONT;
               push = 32'(req_chan.load_index) < 32'(FONT_WORDS);
            end
            OP_LOAD_PALETTE: begin
               push_job.kind = JOB_PALETTE;
               push = 32'(req_chan.load_index) < 32'(PALETTE_DEPTH);
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

endmodule

FILE: rtl/gtb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gtb_queue
   import gtb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      head_job       = slot_ff[rd_ptr_ff];
      q_status.full  = count_ff == CW'(QUEUE_DEPTH);
      q_status.empty = count_ff == '0;
   end

endmodule

FILE: rtl/gtb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter back end
// Runs queued jobs: loads the font and palette stores and draws glyph rows
// through a font read, palette read and output register pipeline.
// ----------------------------------------------------------------------------
module gtb_back
   import gtb_pkg::*;
#(
   parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
   parameter int GLYPH_ROWS   = DEF_GLYPH_ROWS,
   parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  job_type          head_job,
   input  queue_status_type q_status,
   output logic             pop,
   gtb_rsp_if.source        rsp_chan
);

   localparam int          FONT_WORDS = GLYPH_COUNT * GLYPH_ROWS;
   localparam int          FW         = $clog2(FONT_WORDS);
   localparam int          RW         = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
   localparam logic [31:0] ROW_PITCH  = 32'(SCREEN_WIDTH * 2);
   localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_ROWS - 1);

   // Row issue state
   logic          busy_ff, busy_in;
   logic [FW-1:0] ptr_ff, ptr_in;
   logic [31:0]   addr_ff, addr_in;
   logic [RW-1:0] row_ff, row_in;

   logic          adv;
   logic          issue;
   logic          font_we;
   logic          pal_we;
   logic [FW-1:0] cur_ptr;
   logic [31:0]   cur_addr;
   logic [RW-1:0] cur_row;
   logic [FW+3:0] ptr_sum;

   // Font read stage
   logic          s1_valid_ff, s1_valid_in;
   logic [31:0]   s1_addr_ff;
   logic          s1_last_ff;
   logic [31:0]   font_word_ff;
   logic [31:0]   font_mem [FONT_WORDS];

   // Palette read stage
   logic          s2_valid_ff, s2_valid_in;
   logic [31:0]   s2_addr_ff;
   logic          s2_last_ff;
   logic [PIXELS-1:0] s2_mask_ff;
   logic [15:0]   pal_rd_ff [PIXELS];
   logic [3:0]    nib [PIXELS];

   // Output register
   logic          out_valid_ff, out_valid_in;
   logic [31:0]   out_addr_ff;
   logic          out_last_ff;
   logic [PIXELS-1:0] out_mask_ff;
   logic [15:0]   out_color_ff [PIXELS];

   always_comb begin
      adv     = !out_valid_ff || rsp_chan.ready;
      pop     = adv && !busy_ff && !q_status.empty;
      issue   = adv && (busy_ff || (pop && head_job.kind == JOB_DRAW));
      font_we = pop && head_job.kind == JOB_FONT;
      pal_we  = pop && head_job.kind == JOB_PALETTE;

      // A draw issues its first row in the cycle it leaves the queue.
      cur_ptr  = busy_ff ? ptr_ff  : head_job.index[FW-1:0];
      cur_addr = busy_ff ? addr_ff : head_job.address;
      cur_row  = busy_ff ? row_ff  : '0;

      ptr_sum = {4'b0, cur_ptr} + (FW+4)'(8);

      busy_in = busy_ff;
      ptr_in  = ptr_ff;
      addr_in = addr_ff;
      row_in  = row_ff;
      if (issue) begin
         busy_in = cur_row != LAST_ROW;
         if (ptr_sum >= (FW+4)'(FONT_WORDS)) begin
            ptr_in = FW'(ptr_sum - (FW+4)'(FONT_WORDS));
         end else begin
            ptr_in = FW'(ptr_sum);
         end
         addr_in = cur_addr + ROW_PITCH;
         row_in  = RW'(cur_row + 1'b1);
      end

      s1_valid_in  = adv ? issue       : s1_valid_ff;
      s2_valid_in  = adv ? s1_valid_ff : s2_valid_ff;
      out_valid_in = adv ? s2_valid_ff : out_valid_ff;

      for (int i = 0; i < PIXELS; i++) begin
         nib[i] = font_word_ff[31 - 4 * i -: 4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      addr_ff <= addr_in;
      row_ff  <= row_in;
   end

   always_ff @(posedge clock) begin
      if (font_we) begin
         font_mem[head_job.index[FW-1:0]] <= head_job.value;
      end
      if (issue) begin
         font_word_ff <= font_mem[cur_ptr];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_addr_ff <= cur_addr;
         s1_last_ff <= cur_row == LAST_ROW;
      end
   end

   // One palette copy per pixel, so each copy sees a single read address.
   for (genvar P = 0; P < PIXELS; P++) begin : g_pal
      logic [15:0] bank [PALETTE_DEPTH];

      always_ff @(posedge clock) begin
         if (pal_we) begin
            bank[head_job.index[3:0]] <= head_job.value[15:0];
         end
         if (adv) begin
            pal_rd_ff[P] <= bank[nib[P]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_addr_ff <= s1_addr_ff;
         s2_last_ff <= s1_last_ff;
         for (int i = 0; i < PIXELS; i++) begin
            s2_mask_ff[i] <= nib[i] != 4'h0;
         end
         out_addr_ff <= s2_addr_ff;
         out_last_ff <= s2_last_ff;
         out_mask_ff <= s2_mask_ff;
         for (int i = 0; i < PIXELS; i++) begin
            out_color_ff[i] <= s2_mask_ff[i] ? pal_rd_ff[i] : 16'h0000;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.row_address = out_addr_ff;
   assign rsp_chan.color_0     = out_color_ff[0];
   assign rsp_chan.color_1     = out_color_ff[1];
   assign rsp_chan.color_2     = out_color_ff[2];
   assign rsp_chan.color_3     = out_color_ff[3];
   assign rsp_chan.color_4     = out_color_ff[4];
   assign rsp_chan.color_5     = out_color_ff[5];
   assign rsp_chan.color_6     = out_color_ff[6];
   assign rsp_chan.color_7     = out_color_ff[7];
   assign rsp_chan.write_mask  = out_mask_ff;
   assign rsp_chan.last_row    = out_last_ff;

endmodule

FILE: rtl/glyph_text_blitter_4bpp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter, 4bpp font, core
// Front end, job queue and back end of the text overlay engine.
// ----------------------------------------------------------------------------
// A draw item produces GLYPH_ROWS row write items, one per clock while the
// result side keeps taking them, because the back end reads one font word
// per row from its single-port font memory. A glyph passes through the job
// queue, the font read stage, the palette read stage and the output register
// before its first row is offered. Font and palette loads are written into
// their stores as they leave the queue. Cursor items (set cursor, space,
// newline) are handled in the front end in the cycle they are accepted and
// cost the back end nothing. The front end takes a new item every cycle
// while the four-entry job queue has room. Font and palette stores come up
// undefined and need no clearing after reset.
module glyph_text_blitter_4bpp_core
   import gtb_pkg::*;
#(
   parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
   parameter int GLYPH_ROWS   = DEF_GLYPH_ROWS,
   parameter int GLYPH_COUNT  = DEF_GLYPH_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   gtb_req_if.sink     req_chan,
   gtb_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   logic [31:0]      frame_base_ff, frame_base_in;
   logic [7:0]       last_code_ff, last_code_in;

   logic             q_push;
   logic             q_pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
         last_code_ff  <= LAST_CODE_RESET;
      end else begin
         frame_base_ff <= frame_base_in;
         last_code_ff  <= last_code_in;
      end
   end

   always_comb begin
      frame_base_in = frame_base_ff;
      last_code_in  = last_code_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_BASE: frame_base_in = csr_write_data;
            CSR_LAST_CODE:  last_code_in  = csr_write_data[7:0];
            default: begin
               frame_base_in = frame_base_ff;
            end
         endcase
      end
   end

   gtb_front #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .GLYPH_ROWS   (GLYPH_ROWS),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .frame_base (frame_base_ff),
      .last_code  (last_code_ff),
      .q_status   (q_status),
      .push       (q_push),
      .push_job   (push_job)
   );

   gtb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   gtb_back #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .GLYPH_ROWS   (GLYPH_ROWS),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("job queue reports full and empty at once");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job popped from an empty queue");
`endif

endmodule

FILE: tb/gtb_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter checking package
// Command and row write types, and a scoreboard that predicts the row writes
// of every accepted command and checks the rows the blitter sends out.
// ----------------------------------------------------------------------------
package gtb_tb_pkg;
   import gtb_pkg::*;

   localparam int SCREEN_W   = DEF_SCREEN_WIDTH;
   localparam int ROWS       = DEF_GLYPH_ROWS;
   localparam int FONT_WORDS = DEF_GLYPH_COUNT * DEF_GLYPH_ROWS;

   typedef struct {
      opcode_type  op;
      logic [7:0]  char_code;
      logic [15:0] cursor_x;
      logic [15:0] cursor_y;
      logic [11:0] load_index;
      logic [31:0] load_value;
   } text_command_type;

   typedef struct packed {
      logic [31:0]       row_address;
      logic [7:0][15:0]  color;
      logic [7:0]        write_mask;
      logic              last_row;
   } row_write_type;

   // The sheet holds eight glyphs side by side, so a glyph's rows are
   // eight words apart.
   function automatic int glyph_first_word(int glyph);
      return (glyph >> 3) * 8 * ROWS + (glyph & 7);
   endfunction

   class glyph_row_board;
      logic [31:0] frame_base;
      logic [7:0]  last_code;
      logic [31:0] cursor_address;
      logic [15:0] line_x;
      logic [15:0] line_y;
      logic [31:0] font_words [FONT_WORDS];
      logic [15:0] palette [PALETTE_DEPTH];
      row_write_type pending_rows [$];
      int          mismatches;

      function new();
         frame_base     = '0;
         last_code      = LAST_CODE_RESET;
         cursor_address = '0;
         line_x         = '0;
         line_y         = '0;
         mismatches     = 0;
      endfunction

      function void write_register(csr_index_type index, logic [31:0] value);
         if (index == CSR_FRAME_BASE) begin
            frame_base = value;
         end else begin
            last_code = value[7:0];
         end
      endfunction

      function void move_cursor(logic [15:0] x, logic [15:0] y);
         logic [31:0] wide_x;
         logic [31:0] wide_y;
         line_x = x;
         line_y = y;
         wide_x = {{16{x[15]}}, x};
         wide_y = {{16{y[15]}}, y};
         cursor_address = (wide_x + wide_y * 32'(SCREEN_W)) * 32'd2 + frame_base;
      endfunction

      function void take_command(text_command_type cmd);
         logic [7:0]    code;
         int            first_word;
         logic [31:0]   word;
         logic [3:0]    nib;
         row_write_type row;
         case (cmd.op)
            OP_SET_CURSOR: begin
               move_cursor(cmd.cursor_x, cmd.cursor_y);
            end
            OP_LOAD_FONT: begin
               if (cmd.load_index < FONT_WORDS) font_words[cmd.load_index] = cmd.load_value;
            end
            OP_LOAD_PALETTE: begin
               if (cmd.load_index < PALETTE_DEPTH)
                  palette[cmd.load_index] = cmd.load_value[15:0];
            end
            default: begin
               code = cmd.char_code;
               if (code == CODE_SPACE) begin
                  cursor_address += SPACE_ADVANCE;
               end else if (code == CODE_NEWLINE) begin
                  move_cursor(line_x, line_y + LINE_STEP);
               end else begin
                  if (code < CODE_BIAS || code > last_code) code = SUBST_CODE;
                  first_word = glyph_first_word(int'(code - CODE_BIAS));
                  for (int r = 0; r < ROWS; r++) begin
                     word = font_words[(first_word + r * 8) % FONT_WORDS];
                     row.row_address = cursor_address + 32'(r * SCREEN_W * 2);
                     row.write_mask  = '0;
                     for (int p = 0; p < PIXELS; p++) begin
                        nib = word[31 - 4 * p -: 4];
                        if (nib != 0) begin
                           row.color[p]      = palette[nib];
                           row.write_mask[p] = 1'b1;
                        end else begin
                           row.color[p] = '0;
                        end
                     end
                     row.last_row = (r == ROWS - 1);
                     pending_rows.push_back(row);
                  end
                  cursor_address += GLYPH_ADVANCE;
               end
            end
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%s mismatch: expected %h, got %h", name, want, got);
         end
      endfunction

      function void check_row_write(row_write_type got);
         row_write_type want;
         if (pending_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected row write item at address %h", got.row_address);
            return;
         end
         want = pending_rows.pop_front();
         compare_field("row_address", want.row_address, got.row_address);
         for (int p = 0; p < PIXELS; p++)
            compare_field($sformatf("color_%0d", p), want.color[p], got.color[p]);
         compare_field("write_mask", want.write_mask, got.write_mask);
         compare_field("last_row", want.last_row, got.last_row);
      endfunction

      function int outstanding();
         return pending_rows.size();
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph text blitter testbench
// Loads palette and font words, draws glyphs under several frame bases and
// last-code settings, and checks every row write against a prediction made
// when each command item is accepted. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import gtb_pkg::*;
   import gtb_tb_pkg::*;

   localparam int QUIET_CYCLES = 16;
   localparam int LONG_HOLD    = 80;
   localparam int STALL_LIMIT  = 2000;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [31:0] csr_write_data;

   gtb_req_if req_if ();
   gtb_rsp_if rsp_if ();

   glyph_row_board   board;
   text_command_type seen_cmd;
   row_write_type    seen_row;

   bit         font_ready [FONT_WORDS];
   logic [7:0] active_last_code;
   bit         sender_gaps;
   bit         receiver_gaps;
   bit         hold_results;

   glyph_text_blitter_4bpp_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Acceptance monitor: predictions are made in command order at the edge
   // where each item is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            board.write_register(csr_index_type'(csr_index), csr_write_data);
         if (req_if.valid && req_if.ready) begin
            seen_cmd.op         = opcode_type'(req_if.opcode);
            seen_cmd.char_code  = req_if.char_code;
            seen_cmd.cursor_x   = req_if.cursor_x;
            seen_cmd.cursor_y   = req_if.cursor_y;
            seen_cmd.load_index = req_if.load_index;
            seen_cmd.load_value = req_if.load_value;
            board.take_command(seen_cmd);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen_row.row_address = rsp_if.row_address;
            seen_row.color[0]    = rsp_if.color_0;
            seen_row.color[1]    = rsp_if.color_1;
            seen_row.color[2]    = rsp_if.color_2;
            seen_row.color[3]    = rsp_if.color_3;
            seen_row.color[4]    = rsp_if.color_4;
            seen_row.color[5]    = rsp_if.color_5;
            seen_row.color[6]    = rsp_if.color_6;
            seen_row.color[7]    = rsp_if.color_7;
            seen_row.write_mask  = rsp_if.write_mask;
            seen_row.last_row    = rsp_if.last_row;
            board.check_row_write(seen_row);
         end
      end
   end

   // Row write receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_results = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic int glyph_of(logic [7:0] code);
      if (code < CODE_BIAS || code > active_last_code) code = SUBST_CODE;
      return int'(code - CODE_BIAS);
   endfunction

   function automatic bit glyph_loaded(int glyph);
      bit ok;
      ok = 1'b1;
      for (int r = 0; r < ROWS; r++)
         if (!font_ready[glyph_first_word(glyph) + r * 8]) ok = 1'b0;
      return ok;
   endfunction

   function automatic text_command_type fresh_command(opcode_type op);
      text_command_type cmd;
      cmd.op         = op;
      cmd.char_code  = 8'($urandom);
      cmd.cursor_x   = 16'($urandom);
      cmd.cursor_y   = 16'($urandom);
      cmd.load_index = 12'($urandom);
      cmd.load_value = $urandom;
      return cmd;
   endfunction

   // Blank and solid words show up often so that masks hit both extremes.
   function automatic logic [31:0] font_pattern();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_command(text_command_type cmd);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat ($urandom_range(0, 4)) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.opcode     <= cmd.op;
      req_if.char_code  <= cmd.char_code;
      req_if.cursor_x   <= cmd.cursor_x;
      req_if.cursor_y   <= cmd.cursor_y;
      req_if.load_index <= cmd.load_index;
      req_if.load_value <= cmd.load_value;
      if (cmd.op == OP_LOAD_FONT && cmd.load_index < FONT_WORDS)
         font_ready[cmd.load_index] = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   task automatic load_font_word(int index, logic [31:0] value);
      text_command_type cmd;
      cmd = fresh_command(OP_LOAD_FONT);
      cmd.load_index = 12'(index);
      cmd.load_value = value;
      send_command(cmd);
   endtask

   task automatic load_glyph(int glyph);
      for (int r = 0; r < ROWS; r++)
         load_font_word(glyph_first_word(glyph) + r * 8, font_pattern());
   endtask

   task automatic load_palette(int index);
      text_command_type cmd;
      cmd = fresh_command(OP_LOAD_PALETTE);
      cmd.load_index = 12'(index);
      send_command(cmd);
   endtask

   // Never draws a glyph whose font rows are not all written yet.
   task automatic draw(logic [7:0] code);
      text_command_type cmd;
      if (code != CODE_SPACE && code != CODE_NEWLINE && !glyph_loaded(glyph_of(code)))
         load_glyph(glyph_of(code));
      cmd = fresh_command(OP_DRAW);
      cmd.char_code = code;
      send_command(cmd);
   endtask

   task automatic set_cursor(logic [15:0] x, logic [15:0] y);
      text_command_type cmd;
      cmd = fresh_command(OP_SET_CURSOR);
      cmd.cursor_x = x;
      cmd.cursor_y = y;
      send_command(cmd);
   endtask

   task automatic write_register(csr_index_type index, logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      if (index == CSR_LAST_CODE) active_last_code = value[7:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Withdraws the last offered item, waits until every predicted row has
   // arrived, then lets queued loads drain through the back end.
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] base, logic [7:0] last);
      settle();
      write_register(CSR_FRAME_BASE, base);
      write_register(CSR_LAST_CODE, {24'd0, last});
   endtask

   task automatic random_draw();
      logic [7:0] code;
      logic [7:0] pick;
      if ($urandom_range(0, 9) < 9) begin
         code = 8'd0;
         repeat (8) begin
            pick = 8'($urandom_range(0, 255));
            if (pick != CODE_SPACE && pick != CODE_NEWLINE && glyph_loaded(glyph_of(pick)))
               code = pick;
         end
      end else begin
         code = 8'($urandom_range(0, 255));
      end
      draw(code);
   endtask

   task automatic random_items(int count);
      text_command_type cmd;
      int               choice;
      repeat (count) begin
         choice = $urandom_range(0, 99);
         if (choice < 45) begin
            random_draw();
         end else if (choice < 55) begin
            draw(CODE_SPACE);
         end else if (choice < 62) begin
            draw(CODE_NEWLINE);
         end else if (choice < 74) begin
            if ($urandom_range(0, 1) == 0)
               set_cursor(16'($urandom_range(0, 319)), 16'($urandom_range(0, 239)));
            else
               set_cursor(16'($urandom), 16'($urandom));
         end else if (choice < 84) begin
            cmd = fresh_command(OP_LOAD_PALETTE);
            if ($urandom_range(0, 9) < 7) cmd.load_index = 12'($urandom_range(0, 15));
            send_command(cmd);
         end else if (choice < 92) begin
            load_font_word($urandom_range(0, 4095), font_pattern());
         end else begin
            draw(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : stimulus
      board = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_if.valid      = 1'b0;
      req_if.opcode     = '0;
      req_if.char_code  = '0;
      req_if.cursor_x   = '0;
      req_if.cursor_y   = '0;
      req_if.load_index = '0;
      req_if.load_value = '0;
      active_last_code = LAST_CODE_RESET;
      sender_gaps      = 1'b1;
      receiver_gaps    = 1'b1;
      hold_results     = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      write_register(CSR_FRAME_BASE, 32'd0);
      write_register(CSR_LAST_CODE, {24'd0, LAST_CODE_RESET});

      // Whole palette first, then out-of-range loads that must be ignored.
      for (int i = 0; i < PALETTE_DEPTH; i++) load_palette(i);
      load_palette(16);
      load_palette(4095);

      // Substitute glyph with a solid row, a blank row and a checkered row.
      load_glyph(glyph_of(SUBST_CODE));
      load_font_word(glyph_first_word(glyph_of(SUBST_CODE)), 32'hFFFF_FFFF);
      load_font_word(glyph_first_word(glyph_of(SUBST_CODE)) + 8, 32'h0000_0000);
      load_font_word(glyph_first_word(glyph_of(SUBST_CODE)) + 16, 32'h0F0F_0F0F);
      load_font_word(FONT_WORDS, 32'hDEAD_BEEF);
      load_font_word(4095, 32'h1234_5678);

      set_cursor(16'h8000, 16'h8000);
      draw(8'd0);
      set_cursor(16'h7FFF, 16'h7FFF);
      draw(8'd14);
      draw(CODE_SPACE);
      draw(8'd128);
      draw(CODE_NEWLINE);   // line_y wraps past the top of the signed range
      draw(8'd255);
      set_cursor(16'd0, 16'd0);
      draw(CODE_BIAS);
      draw(8'd127);
      draw(CODE_NEWLINE);
      draw(8'd65);

      // Widest settings; the result side holds off while draws pile up.
      configure(32'hFFFF_FFFF, 8'd255);
      draw(8'd255);
      hold_results = 1'b1;
      sender_gaps  = 1'b0;
      repeat (8) random_draw();
      sender_gaps  = 1'b1;
      random_items(25);

      // Every printable code falls back to the substitute glyph here.
      configure($urandom, 8'd0);
      random_items(40);

      configure($urandom, 8'($urandom_range(15, 254)));
      random_items(25);

      configure(32'd0, LAST_CODE_RESET);
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      random_items(25);

      @(negedge clock);
      req_if.valid <= 1'b0;
      settle();
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
